// ===== hw/rtl/awsp_pkg.sv =====
package awsp_pkg;

  // configuration register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_TARGET_WINDOW      = 3'd0;
  localparam logic [2:0] REG_INITIAL_WINDOW     = 3'd1;
  localparam logic [2:0] REG_SEND_INTERVAL_NS   = 3'd2;
  localparam logic [2:0] REG_OWN_ID             = 3'd3;
  localparam logic [2:0] REG_IS_SERVER          = 3'd4;
  localparam logic [2:0] REG_INITIAL_PEER       = 3'd5;
  localparam logic [2:0] REG_INITIAL_PEER_KNOWN = 3'd6;

  // input kinds
  localparam logic CMD_ACK  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ACK_USED = 2'd0;
  localparam logic [1:0] ST_NOT_ACK  = 2'd1;
  localparam logic [1:0] ST_FOREIGN  = 2'd2;
  localparam logic [1:0] ST_TICK     = 2'd3;

  // configuration reset values
  localparam logic [15:0] TARGET_WINDOW_RST  = 16'd2500;
  localparam logic [15:0] INITIAL_WINDOW_RST = 16'd32;
  localparam logic [31:0] SEND_INTERVAL_RST  = 32'd1000000;

  localparam logic [30:0] UNKNOWN_WAIT_NS = 31'd1000000000;
  localparam logic [30:0] WAIT_MAX        = 31'h7FFF_FFFF;
  localparam logic [15:0] WINDOW_DROP     = 16'd20;
  localparam logic [15:0] BURST_MAX       = 16'hFFFF;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 144;

endpackage

// ===== hw/rtl/ack_window_send_pacer_top.sv =====
// Sender-side window controller. Each input item is an ack event (tuser = 0) or a send
// tick (tuser = 1) and yields exactly one result. One item is taken every clock cycle
// unless m_tready low holds the result register; an item passes the input register, then
// the result register, as the whole update of the window, counters and pacing timer is one
// combinational pass between those two registers. When the result register is
// held by m_tready low, one further item is still taken into the input register.
// Configuration is through a 64-bit APB port, register i at byte address 8*i; writing
// initial_window, initial_peer or initial_peer_known also loads the live window, peer
// address or peer-known flag. Write configuration only while no item is in flight.
module ack_window_send_pacer_top
  import awsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now_ns[62:0], seq_number[94:63], ack_seq[126:95], src_id[142:127],
  // source_addr[190:143], zero[191]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[0]
  input  logic                  s_tuser,
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // send_count[15:0], first_seq[46:16], dest_addr[94:47], wait_ns[125:95],
  // window_now[141:126], zero[143:142]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]            m_tuser,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [15:0] target_window;
  logic [15:0] initial_window;
  logic [31:0] send_interval_ns;
  logic [15:0] own_id;
  logic        is_server;
  logic [47:0] initial_peer;
  logic        initial_peer_known;

  // controller state
  logic [15:0] window;
  logic [31:0] packets_sent;
  logic [31:0] max_acked;
  logic [63:0] next_send_time;
  logic [16:0] newest_peer_id;
  logic [47:0] peer_addr;
  logic        peer_known;

  // input register
  logic        in_vld;
  logic        in_cmd;
  logic [62:0] in_now;
  logic [31:0] in_seq;
  logic [31:0] in_ack;
  logic [15:0] in_sid;
  logic [47:0] in_src;

  // result register
  logic        out_vld;
  logic [15:0] out_count;
  logic [30:0] out_first;
  logic [47:0] out_dest;
  logic [30:0] out_wait;
  logic [1:0]  out_status;
  logic [15:0] out_window;

  // next state and result
  logic [15:0] window_next;
  logic [31:0] packets_sent_next;
  logic [31:0] max_acked_next;
  logic [63:0] next_send_time_next;
  logic [16:0] newest_peer_id_next;
  logic [47:0] peer_addr_next;
  logic        peer_known_next;
  logic [15:0] count_next;
  logic [30:0] first_next;
  logic [30:0] wait_next;
  logic [1:0]  status_next;

  logic        adv;
  logic        cfg_wr;

  assign adv      = !out_vld || m_tready;
  assign s_tready = !in_vld || adv;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  assign m_tvalid = out_vld;
  assign m_tuser  = out_status;
  assign m_tdata  = {2'b00, out_window, out_wait, out_dest, out_first, out_count};

  always_comb begin
    logic [31:0] outs;
    logic        burst_ok;
    logic [33:0] amt;
    logic        timed;
    logic [63:0] now64;
    logic [63:0] send_at;
    logic [31:0] outs_n;
    logic        lt_n;
    logic [63:0] diff;

    now64    = {1'b0, in_now};
    send_at  = now64 + {32'd0, send_interval_ns};
    outs     = packets_sent - max_acked - 32'd1;
    burst_ok = $signed({outs[31], outs}) < $signed({17'd0, window});
    amt      = {18'd0, window} - {{2{outs[31]}}, outs};
    timed    = next_send_time < now64;

    window_next         = window;
    packets_sent_next   = packets_sent;
    max_acked_next      = max_acked;
    next_send_time_next = next_send_time;
    newest_peer_id_next = newest_peer_id;
    peer_addr_next      = peer_addr;
    peer_known_next     = peer_known;
    count_next          = '0;
    first_next          = '0;
    status_next         = ST_TICK;

    case (in_cmd)
      CMD_ACK: begin
        if (in_seq != '1) begin
          status_next = ST_NOT_ACK;
        end else begin
          // server roams to a higher-numbered peer announcing itself
          if (is_server && ($signed({1'b0, in_sid}) > $signed(newest_peer_id))
              && (in_ack == '1)) begin
            newest_peer_id_next = {1'b0, in_sid};
            peer_addr_next      = in_src;
            peer_known_next     = 1'b1;
          end
          if (in_sid != own_id) begin
            status_next = ST_FOREIGN;
          end else begin
            status_next = ST_ACK_USED;
            if ($signed(in_ack) > $signed(max_acked)) begin
              max_acked_next = in_ack;
            end
            if (window < target_window) begin
              window_next = window + 16'd1;
            end else if (window > target_window) begin
              window_next = (window > WINDOW_DROP) ? window - WINDOW_DROP : 16'd0;
            end
          end
        end
      end
      default: begin
        status_next = ST_TICK;
        if (peer_known) begin
          if (burst_ok) begin
            count_next          = (|amt[33:16]) ? BURST_MAX : amt[15:0];
            packets_sent_next   = packets_sent + {16'd0, count_next};
            next_send_time_next = send_at;
          end else if (timed) begin
            count_next          = 16'd1;
            packets_sent_next   = packets_sent + 32'd1;
            next_send_time_next = send_at;
          end
          if (count_next != '0) begin
            first_next = packets_sent[30:0];
          end
        end
      end
    endcase

    // wait time seen from the updated state
    outs_n = packets_sent_next - max_acked_next - 32'd1;
    lt_n   = $signed({outs_n[31], outs_n}) < $signed({17'd0, window_next});
    diff   = next_send_time_next - now64;
    if (!peer_known_next) begin
      wait_next = UNKNOWN_WAIT_NS;
    end else if (lt_n || (next_send_time_next <= now64)) begin
      wait_next = '0;
    end else if (|diff[63:31]) begin
      wait_next = WAIT_MAX;
    end else begin
      wait_next = diff[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld <= 1'b1;
      end else if (adv) begin
        in_vld <= 1'b0;
      end
      if (adv) begin
        out_vld <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_now <= s_tdata[62:0];
      in_seq <= s_tdata[94:63];
      in_ack <= s_tdata[126:95];
      in_sid <= s_tdata[142:127];
      in_src <= s_tdata[190:143];
    end
    if (adv && in_vld) begin
      out_count  <= count_next;
      out_first  <= first_next;
      out_dest   <= peer_addr_next;
      out_wait   <= wait_next;
      out_status <= status_next;
      out_window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_window      <= TARGET_WINDOW_RST;
      initial_window     <= INITIAL_WINDOW_RST;
      send_interval_ns   <= SEND_INTERVAL_RST;
      own_id             <= '0;
      is_server          <= 1'b0;
      initial_peer       <= '0;
      initial_peer_known <= 1'b0;
      window             <= INITIAL_WINDOW_RST;
      packets_sent       <= '0;
      max_acked          <= '1;
      next_send_time     <= '0;
      newest_peer_id     <= '1;
      peer_addr          <= '0;
      peer_known         <= 1'b0;
    end else begin
      if (adv && in_vld) begin
        window         <= window_next;
        packets_sent   <= packets_sent_next;
        max_acked      <= max_acked_next;
        next_send_time <= next_send_time_next;
        newest_peer_id <= newest_peer_id_next;
        peer_addr      <= peer_addr_next;
        peer_known     <= peer_known_next;
      end
      if (cfg_wr) begin
        unique case (paddr[5:3])
          REG_TARGET_WINDOW:    target_window <= pwdata[15:0];
          REG_INITIAL_WINDOW: begin
            initial_window <= pwdata[15:0];
            window         <= pwdata[15:0];
          end
          REG_SEND_INTERVAL_NS: send_interval_ns <= pwdata[31:0];
          REG_OWN_ID:           own_id <= pwdata[15:0];
          REG_IS_SERVER:        is_server <= pwdata[0];
          REG_INITIAL_PEER: begin
            initial_peer <= pwdata[47:0];
            peer_addr    <= pwdata[47:0];
          end
          REG_INITIAL_PEER_KNOWN: begin
            initial_peer_known <= pwdata[0];
            peer_known         <= pwdata[0];
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_TARGET_WINDOW:      prdata = {48'd0, target_window};
      REG_INITIAL_WINDOW:     prdata = {48'd0, initial_window};
      REG_SEND_INTERVAL_NS:   prdata = {32'd0, send_interval_ns};
      REG_OWN_ID:             prdata = {48'd0, own_id};
      REG_IS_SERVER:          prdata = {63'd0, is_server};
      REG_INITIAL_PEER:       prdata = {16'd0, initial_peer};
      REG_INITIAL_PEER_KNOWN: prdata = {63'd0, initial_peer_known};
      default:                prdata = '0;
    endcase
  end

  // no packets reported means no first sequence number
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_count == '0) |-> (out_first == '0))
    else $error("first_seq nonzero with no packets to send");

  // only ticks send packets
  a_ack_no_send: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_TICK) |-> (out_count == '0))
    else $error("ack event reported packets to send");

  // an item held by a stalled result stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_vld && out_vld && !m_tready |=> in_vld && $stable(in_now) && $stable(in_cmd))
    else $error("input register lost its item during a stall");

endmodule
